### design/blocked_queens_counter_macros.svh
// Assertion macros used by the blocked queens counter checker.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef BLOCKED_QUEENS_COUNTER_MACROS_SVH
`define BLOCKED_QUEENS_COUNTER_MACROS_SVH

// Same-cycle implication, masked during reset.
`define BQC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, masked during reset.
`define BQC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/bqc_pkg.sv
// Shared types and constants for the blocked queens counter.
// No dependencies; used by bqc_ctrl, bqc_dpath and the top level.
package bqc_pkg;

	localparam int ROW_IDX_W   = 3;
	localparam int MASK_W      = 8;
	localparam int COUNT_W     = 7;
	localparam int STORE_DEPTH = 8;
	localparam int STORE_AW    = 3;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;       // write the incoming row into the board store
		logic start;      // clear the search state for a new search
		logic place;      // put a queen on the lowest free row of this column
		logic retreat;    // lift the queen of the previous column
		logic count_inc;  // a full placement was reached
		logic emit;       // copy the count into the result register
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic last_row;   // incoming row index is the last board row
		logic full;       // every column holds a queen
		logic root;       // search is at the first column
		logic avail_any;  // a free row remains in the current column
	} stat_t;

endpackage

### design/bqc_ctrl.sv
// Controller state machine for the blocked queens counter.
// Depends on bqc_pkg for the command and status structs.
module bqc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  bqc_pkg::stat_t  stat,
	output bqc_pkg::cmd_t   cmd
);
	import bqc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load  = accept;
				cmd.start = accept && stat.last_row;
			end
			ST_SEARCH: begin
				if (stat.full) begin
					cmd.count_inc = 1'b1;
					cmd.retreat   = 1'b1;
				end else if (stat.avail_any) begin
					cmd.place = 1'b1;
				end else if (!stat.root) begin
					cmd.retreat = 1'b1;
				end
			end
			ST_DONE: begin
				cmd.emit = !out_valid_q || !out_stall;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					if (!stat.full && !stat.avail_any && stat.root) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (cmd.emit) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### design/bqc_dpath.sv
// Datapath of the blocked queens counter: board store, occupancy masks,
// choice stack, column and row cursors, count. Depends on bqc_pkg.
module bqc_dpath #(
	parameter int BOARD_SIZE = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [bqc_pkg::ROW_IDX_W-1:0]  row_index,
	input  logic [bqc_pkg::MASK_W-1:0]     blocked_mask,
	input  bqc_pkg::cmd_t                  cmd,
	output bqc_pkg::stat_t                 stat,
	output logic [bqc_pkg::COUNT_W-1:0]    solution_count
);
	import bqc_pkg::*;

	localparam int N     = BOARD_SIZE;
	localparam int RowW  = $clog2(N);
	localparam int ColW  = $clog2(N + 1);
	localparam int DiagW = 2 * N - 1;
	localparam int DIW   = $clog2(DiagW);

	logic [MASK_W-1:0]  store_q [STORE_DEPTH];
	logic [N-1:0]       rows_q;
	logic [DiagW-1:0]   diag_q;
	logic [DiagW-1:0]   anti_q;
	logic [RowW-1:0]    stack_q [N];
	logic [ColW-1:0]    col_q;
	logic [ColW-1:0]    try_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] result_q;

	logic [N-1:0]       blk;
	logic [N-1:0]       ge_mask;
	logic [N-1:0]       avail;
	logic [DiagW-1:0]   diag_sh;
	logic [DiagW-1:0]   anti_sh;
	logic [DIW-1:0]     diag_shift;
	logic [RowW-1:0]    pick;
	logic [ColW-1:0]    col_m1;
	logic [RowW-1:0]    prev;
	logic [DIW-1:0]     d_place;
	logic [DIW-1:0]     a_place;
	logic [DIW-1:0]     d_ret;
	logic [DIW-1:0]     a_ret;

	// Column of blocked cells for the current column, one bit per row
	always_comb begin
		blk = '0;
		for (int r = 0; r < N; r++) begin
			if (r < STORE_DEPTH) begin
				blk[r] = |(store_q[r[STORE_AW-1:0]] & (MASK_W'(1) << col_q));
			end
		end
	end

	always_comb begin
		for (int i = 0; i < N; i++) begin
			ge_mask[i] = (ColW'(i) >= try_q);
		end
	end

	assign diag_shift = DIW'(N - 1) - DIW'(col_q);
	assign diag_sh    = diag_q >> diag_shift;
	assign anti_sh    = anti_q >> col_q;
	assign avail      = ~rows_q & ~diag_sh[N-1:0] & ~anti_sh[N-1:0] & ~blk & ge_mask;

	// Lowest free row at or above the try cursor
	always_comb begin
		pick = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (avail[i]) pick = RowW'(i);
		end
	end

	assign col_m1  = col_q - ColW'(1);
	assign prev    = stack_q[col_m1[RowW-1:0]];
	assign d_place = DIW'(pick) + DIW'(N - 1) - DIW'(col_q);
	assign a_place = DIW'(pick) + DIW'(col_q);
	assign d_ret   = DIW'(prev) + DIW'(N) - DIW'(col_q);
	assign a_ret   = DIW'(prev) + DIW'(col_m1);

	assign stat.last_row  = (int'(row_index) == N - 1);
	assign stat.full      = (col_q == ColW'(N));
	assign stat.root      = (col_q == '0);
	assign stat.avail_any = |avail;

	assign solution_count = result_q;

	always_ff @(posedge clk) begin
		if (cmd.load) store_q[row_index] <= blocked_mask;
		if (cmd.emit) result_q <= count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= '0;
			diag_q  <= '0;
			anti_q  <= '0;
			col_q   <= '0;
			try_q   <= '0;
			count_q <= '0;
			for (int i = 0; i < N; i++) stack_q[i] <= '0;
		end else if (cmd.start) begin
			rows_q  <= '0;
			diag_q  <= '0;
			anti_q  <= '0;
			col_q   <= '0;
			try_q   <= '0;
			count_q <= '0;
		end else begin
			if (cmd.count_inc && count_q != COUNT_MAX) count_q <= count_q + COUNT_W'(1);
			if (cmd.place) begin
				rows_q                   <= rows_q | (N'(1) << pick);
				diag_q                   <= diag_q | (DiagW'(1) << d_place);
				anti_q                   <= anti_q | (DiagW'(1) << a_place);
				stack_q[col_q[RowW-1:0]] <= pick;
				col_q                    <= col_q + ColW'(1);
				try_q                    <= '0;
			end else if (cmd.retreat) begin
				rows_q <= rows_q & ~(N'(1) << prev);
				diag_q <= diag_q & ~(DiagW'(1) << d_ret);
				anti_q <= anti_q & ~(DiagW'(1) << a_ret);
				col_q  <= col_m1;
				try_q  <= ColW'(prev) + ColW'(1);
			end
		end
	end

endmodule

### design/blocked_queens_counter.sv
// Top level of the blocked queens counter.
// Depends on bqc_pkg, bqc_ctrl and bqc_dpath.
//
// Usage:
//   Input channel (in_valid / in_stall): each transaction loads one board row,
//   row_index selects the row and blocked_mask marks its blocked cells (bit c
//   is column c). A transaction whose row_index is BOARD_SIZE-1 also starts
//   the search; every other row only updates the board and gives no result.
//   Load every row before the last one, since a row is read only after a write.
//   Output channel (out_valid / out_stall): one transaction per search carries
//   solution_count, the number of ways to place BOARD_SIZE non-attacking
//   queens on free cells.
//   Plain rows can be loaded back to back while no search runs.
//   A search runs one step per cycle in the place/retreat loop of the
//   datapath: each step places a queen, lifts a queen (counting a full
//   placement as it does so) or closes the search; the count is then handed
//   to the output register. in_stall is high for the whole search.
//   The output register holds the count while the receiver stalls; new rows
//   are still taken in the meantime, and a following search waits at its end
//   until that register frees up.
//   Reset (arst_n low) clears the search state and the output valid; the
//   board store is not cleared.
module blocked_queens_counter #(
	parameter int BOARD_SIZE = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [bqc_pkg::ROW_IDX_W-1:0]  row_index,
	input  logic [bqc_pkg::MASK_W-1:0]     blocked_mask,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [bqc_pkg::COUNT_W-1:0]    solution_count
);
	import bqc_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Sequence the search: accept rows, step the search, hand off the count
	bqc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Hold the board, the occupancy masks and the stack of chosen rows
	bqc_dpath #(
		.BOARD_SIZE (BOARD_SIZE)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.row_index      (row_index),
		.blocked_mask   (blocked_mask),
		.cmd            (cmd),
		.stat           (stat),
		.solution_count (solution_count)
	);

endmodule

### design/bqc_checker.sv
// Port-level checker for the blocked queens counter, bound to the top level.
// Depends on blocked_queens_counter_macros.svh.
`include "blocked_queens_counter_macros.svh"

module bqc_checker #(
	parameter int BOARD_SIZE = 8
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [2:0] row_index,
	input logic       out_valid,
	input logic       out_stall,
	input logic [6:0] solution_count
);

	`BQC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

	`BQC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(solution_count), "stalled result changed")

	`BQC_ASSERT_NOW(a_count_range, out_valid, (BOARD_SIZE <= 8) && (solution_count <= 7'd92), "count out of range")

	`BQC_ASSERT_NEXT(a_search_busy, in_valid && !in_stall && (row_index == BOARD_SIZE - 1), in_stall, "input taken during search")

	`BQC_ASSERT_NEXT(a_no_spurious, in_valid && !in_stall && (row_index != BOARD_SIZE - 1) && !out_valid, !out_valid, "result after a plain row")

endmodule

bind blocked_queens_counter bqc_checker #(.BOARD_SIZE(BOARD_SIZE)) u_bqc_checker (.*);
